// ===== sv/ilt_pkg.sv =====
// ----------------------------------------------------------------------------
// ilt_pkg
// Types, character codes and result codes shared by the INI line tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ilt_pkg;

    localparam int POS_W     = 16;
    localparam int LINE_W    = 16;
    localparam int SLINE_W   = 17;
    localparam int BYTE_W    = 8;
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_LBR   = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBR   = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_SECT      = 9'b000000010,
        ST_SECT_END  = 9'b000000100,
        ST_COMMENT   = 9'b000001000,
        ST_DELIM     = 9'b000010000,
        ST_VALUE     = 9'b000100000,
        ST_VALUE_END = 9'b001000000,
        ST_CMT_VALUE = 9'b010000000,
        ST_CMT_EMPTY = 9'b100000000
    } pstate_t;

    typedef enum logic [2:0] {
        EV_PROP   = 3'd0,
        EV_BR_EOL = 3'd1,
        EV_DL_EOL = 3'd2,
        EV_BR_CMT = 3'd3,
        EV_DL_CMT = 3'd4,
        EV_BR_END = 3'd5,
        EV_DL_END = 3'd6,
        EV_END    = 3'd7
    } event_t;

    typedef struct packed {
        event_t                    event_res;
        logic [POS_W-1:0]          section_start;
        logic [POS_W-1:0]          section_length;
        logic signed [SLINE_W-1:0] section_line;
        logic signed [SLINE_W-1:0] section_column;
        logic [POS_W-1:0]          key_start;
        logic [POS_W-1:0]          key_length;
        logic [POS_W-1:0]          value_start;
        logic [POS_W-1:0]          value_length;
        logic [LINE_W-1:0]         line_number;
        logic [POS_W-1:0]          column;
        logic                      run_end;
    } res_t;

    typedef struct packed {
        pstate_t                   st;
        logic [POS_W-1:0]          pos;
        logic [POS_W-1:0]          line_start;
        logic [LINE_W-1:0]         line_count;
        logic [POS_W-1:0]          token_begin;
        logic [POS_W-1:0]          last_ns;
        logic [POS_W-1:0]          key_begin;
        logic [POS_W-1:0]          key_len;
        logic [POS_W-1:0]          sect_begin;
        logic [POS_W-1:0]          sect_len;
        logic signed [SLINE_W-1:0] sect_line;
        logic signed [SLINE_W-1:0] sect_col;
        logic                      halted;
    } state_t;

    localparam state_t STATE_RST = '{
        st:          ST_IDLE,
        pos:         '0,
        line_start:  '0,
        line_count:  '0,
        token_begin: '0,
        last_ns:     '0,
        key_begin:   '0,
        key_len:     '0,
        sect_begin:  '0,
        sect_len:    '0,
        sect_line:   '1,
        sect_col:    '1,
        halted:      1'b0
    };

endpackage

`default_nettype wire

// ===== sv/ilt_step.sv =====
// ----------------------------------------------------------------------------
// ilt_step
// Next-state and result logic for one text byte of the INI tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

module ilt_step (
    input  var ilt_pkg::state_t                  cur,
    input  wire logic [ilt_pkg::BYTE_W-1:0]      byte_value,
    input  wire logic                            final_byte,
    output ilt_pkg::state_t                      nxt,
    output ilt_pkg::res_t                        res0,
    output ilt_pkg::res_t                        res1,
    output logic [1:0]                           res_cnt
);

    function automatic logic pending(ilt_pkg::pstate_t s);
        return (s == ilt_pkg::ST_VALUE) || (s == ilt_pkg::ST_VALUE_END) ||
               (s == ilt_pkg::ST_CMT_VALUE) || (s == ilt_pkg::ST_CMT_EMPTY);
    endfunction

    // A byte with no special meaning in the current state.
    function automatic ilt_pkg::state_t as_ord(ilt_pkg::state_t x,
                                               logic [ilt_pkg::BYTE_W-1:0] c);
        ilt_pkg::state_t y;
        y = x;
        case (x.st)
            ilt_pkg::ST_SECT:
            begin
                y.token_begin = x.pos;
                y.last_ns     = x.pos;
                y.st          = ilt_pkg::ST_SECT_END;
            end
            ilt_pkg::ST_VALUE:
            begin
                y.token_begin = x.pos;
                y.last_ns     = x.pos;
                y.st          = ilt_pkg::ST_VALUE_END;
            end
            ilt_pkg::ST_SECT_END, ilt_pkg::ST_DELIM, ilt_pkg::ST_VALUE_END:
            begin
                if (c != ilt_pkg::CH_SPACE)
                begin
                    y.last_ns = x.pos;
                end
            end
            default:
            begin
            end
        endcase
        return y;
    endfunction

    function automatic ilt_pkg::res_t simple(ilt_pkg::event_t ev,
                                             logic [ilt_pkg::LINE_W-1:0] ln,
                                             logic [ilt_pkg::POS_W-1:0] col);
        ilt_pkg::res_t r;
        r             = '0;
        r.event_res   = ev;
        r.line_number = ln;
        r.column      = col;
        return r;
    endfunction

    function automatic ilt_pkg::res_t prop(ilt_pkg::state_t x);
        ilt_pkg::res_t r;
        logic          empty;
        empty            = (x.st == ilt_pkg::ST_VALUE) || (x.st == ilt_pkg::ST_CMT_EMPTY);
        r                = '0;
        r.event_res      = ilt_pkg::EV_PROP;
        r.section_start  = x.sect_begin;
        r.section_length = x.sect_len;
        r.section_line   = x.sect_line;
        r.section_column = x.sect_col;
        r.key_start      = x.key_begin;
        r.key_length     = x.key_len;
        r.value_start    = empty ? '0 : x.token_begin;
        r.value_length   = empty ? '0 : ilt_pkg::POS_W'(x.last_ns + 16'd1 - x.token_begin);
        r.line_number    = x.line_count;
        r.column         = ilt_pkg::POS_W'(x.key_begin - x.line_start);
        return r;
    endfunction

    ilt_pkg::pstate_t         s;
    logic [ilt_pkg::POS_W-1:0] p;
    ilt_pkg::res_t            line_r;
    ilt_pkg::res_t            fin_r;
    ilt_pkg::res_t            end_r;
    logic                     line_v;
    logic                     fin_v;
    logic                     end_v;
    logic                     err;
    logic                     fin_err;
    logic                     v1;

    always_comb
    begin
        s       = cur.st;
        p       = cur.pos;
        nxt     = cur;
        line_r  = '0;
        fin_r   = '0;
        end_r   = simple(ilt_pkg::EV_END, '0, '0);
        line_v  = 1'b0;
        fin_v   = 1'b0;
        end_v   = 1'b0;
        err     = 1'b0;
        fin_err = 1'b0;

        if (cur.halted)
        begin
            if (final_byte)
            begin
                nxt = ilt_pkg::STATE_RST;
            end
        end
        else
        begin
            if (byte_value == ilt_pkg::CH_SPACE)
            begin
                if (!(s inside {ilt_pkg::ST_IDLE, ilt_pkg::ST_DELIM, ilt_pkg::ST_VALUE}))
                begin
                    nxt = as_ord(cur, byte_value);
                end
            end
            else if (byte_value == ilt_pkg::CH_LBR)
            begin
                if (s == ilt_pkg::ST_IDLE)
                begin
                    nxt.token_begin = p;
                    nxt.last_ns     = p;
                    nxt.st          = ilt_pkg::ST_SECT;
                end
                else
                begin
                    nxt = as_ord(cur, byte_value);
                end
            end
            else if (byte_value == ilt_pkg::CH_RBR)
            begin
                if (s inside {ilt_pkg::ST_SECT, ilt_pkg::ST_SECT_END})
                begin
                    nxt.sect_begin = cur.token_begin;
                    nxt.sect_len   = (s == ilt_pkg::ST_SECT) ? '0 :
                                     ilt_pkg::POS_W'(p - cur.token_begin);
                    nxt.sect_line  = {1'b0, cur.line_count};
                    nxt.sect_col   = {1'b0, ilt_pkg::POS_W'(cur.token_begin - cur.line_start)};
                    nxt.st         = ilt_pkg::ST_IDLE;
                end
                else
                begin
                    nxt = as_ord(cur, byte_value);
                end
            end
            else if (byte_value == ilt_pkg::CH_LF)
            begin
                if ((s == ilt_pkg::ST_IDLE) || (s == ilt_pkg::ST_COMMENT) || pending(s))
                begin
                    if (pending(s))
                    begin
                        line_r = prop(cur);
                        line_v = 1'b1;
                    end
                    nxt.st         = ilt_pkg::ST_IDLE;
                    nxt.line_count = ilt_pkg::LINE_W'(cur.line_count + 16'd1);
                    nxt.line_start = ilt_pkg::POS_W'(p + 16'd1);
                end
                else
                begin
                    line_r = simple((s == ilt_pkg::ST_DELIM) ? ilt_pkg::EV_DL_EOL :
                                    ilt_pkg::EV_BR_EOL, cur.line_count,
                                    ilt_pkg::POS_W'(p - cur.line_start));
                    line_v = 1'b1;
                    err    = 1'b1;
                end
            end
            else if ((byte_value == ilt_pkg::CH_HASH) || (byte_value == ilt_pkg::CH_SEMI))
            begin
                if (s inside {ilt_pkg::ST_IDLE, ilt_pkg::ST_COMMENT})
                begin
                    nxt.st = ilt_pkg::ST_COMMENT;
                end
                else if (s inside {ilt_pkg::ST_VALUE, ilt_pkg::ST_CMT_EMPTY})
                begin
                    nxt.st = ilt_pkg::ST_CMT_EMPTY;
                end
                else if (s inside {ilt_pkg::ST_VALUE_END, ilt_pkg::ST_CMT_VALUE})
                begin
                    nxt.st = ilt_pkg::ST_CMT_VALUE;
                end
                else
                begin
                    line_r = simple((s == ilt_pkg::ST_DELIM) ? ilt_pkg::EV_DL_CMT :
                                    ilt_pkg::EV_BR_CMT, cur.line_count,
                                    ilt_pkg::POS_W'(p - cur.line_start));
                    line_v = 1'b1;
                    err    = 1'b1;
                end
            end
            else if (((byte_value == ilt_pkg::CH_EQ) || (byte_value == ilt_pkg::CH_COLON)) &&
                     (s == ilt_pkg::ST_DELIM))
            begin
                nxt.key_begin = cur.token_begin;
                nxt.key_len   = ilt_pkg::POS_W'(cur.last_ns + 16'd1 - cur.token_begin);
                nxt.st        = ilt_pkg::ST_VALUE;
            end
            else if (s == ilt_pkg::ST_IDLE)
            begin
                nxt.st          = ilt_pkg::ST_DELIM;
                nxt.token_begin = p;
                nxt.last_ns     = p;
            end
            else
            begin
                nxt = as_ord(cur, byte_value);
            end

            if (err)
            begin
                nxt.halted = 1'b1;
                if (final_byte)
                begin
                    nxt = ilt_pkg::STATE_RST;
                end
            end
            else
            begin
                nxt.pos = ilt_pkg::POS_W'(p + 16'd1);
                if (final_byte)
                begin
                    // The end of text closes a pending value or flags an open line.
                    if (pending(nxt.st))
                    begin
                        fin_r = prop(nxt);
                        fin_v = 1'b1;
                    end
                    else if (nxt.st inside {ilt_pkg::ST_SECT, ilt_pkg::ST_SECT_END,
                                            ilt_pkg::ST_DELIM})
                    begin
                        fin_r   = simple((nxt.st == ilt_pkg::ST_DELIM) ? ilt_pkg::EV_DL_END :
                                         ilt_pkg::EV_BR_END, nxt.line_count,
                                         ilt_pkg::POS_W'(nxt.pos - nxt.line_start));
                        fin_v   = 1'b1;
                        fin_err = 1'b1;
                    end
                    end_v = !fin_err;
                    nxt   = ilt_pkg::STATE_RST;
                end
            end
        end

        // A newline and the end of text never both yield a result from the line.
        res0 = line_v ? line_r : (fin_v ? fin_r : end_r);
        res1 = line_v ? (fin_v ? fin_r : end_r) : end_r;
        v1   = (line_v && (fin_v || end_v)) || (fin_v && end_v);
        res0.run_end = !v1;
        res1.run_end = 1'b1;
        if (v1)
        begin
            res_cnt = 2'd2;
        end
        else if (line_v || fin_v || end_v)
        begin
            res_cnt = 2'd1;
        end
        else
        begin
            res_cnt = 2'd0;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ilt_res_fifo.sv =====
// ----------------------------------------------------------------------------
// ilt_res_fifo
// Small result queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module ilt_res_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [1:0]    wr_cnt,
    input  var ilt_pkg::res_t  wr0,
    input  var ilt_pkg::res_t  wr1,
    output logic               room_two,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output ilt_pkg::res_t      rd_data
);

    ilt_pkg::res_t                  mem_reg [ilt_pkg::RES_DEPTH];
    logic [ilt_pkg::RES_PTR_W-1:0] wr_ptr_reg;
    logic [ilt_pkg::RES_PTR_W-1:0] wr_ptr_next;
    logic [ilt_pkg::RES_PTR_W-1:0] rd_ptr_reg;
    logic [ilt_pkg::RES_PTR_W-1:0] rd_ptr_next;
    logic [ilt_pkg::RES_CNT_W-1:0] count_reg;
    logic [ilt_pkg::RES_CNT_W-1:0] count_next;
    logic                          pop;

    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;
    assign room_two = (count_reg <= ilt_pkg::RES_CNT_W'(ilt_pkg::RES_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ilt_pkg::RES_PTR_W'(wr_cnt);
        rd_ptr_next = rd_ptr_reg + ilt_pkg::RES_PTR_W'(pop);
        count_next  = count_reg + ilt_pkg::RES_CNT_W'(wr_cnt) - ilt_pkg::RES_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wr0;
        end
        if (wr_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + ilt_pkg::RES_PTR_W'(1)] <= wr1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ini_line_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// ini_line_tokenizer_unit
// Streaming INI tokenizer: one text byte in, property and error items out.
// ----------------------------------------------------------------------------
// The unit takes one text byte per clock cycle; the parser state is updated in
// the cycle a byte is accepted, and its results enter a four-entry result queue
// that drives the output stream one item per cycle. A byte is taken whenever
// that queue has room for two items, so with a consumer that keeps up the input
// never stalls; only the last byte of a text can yield two items (a pending
// property and the end marker). s_tlast marks the last byte of a text, after
// which the unit is back in its reset state, and m_tlast marks the last item
// caused by one byte. After an error, bytes are swallowed up to the last one.
`default_nettype none

module ini_line_tokenizer_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,    // [7:0] byte_value
    input  wire logic         s_tlast,    // final_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [2:0] event_res, [18:3] section_start, [34:19] section_length,
    // [51:35] section_line, [68:52] section_column, [84:69] key_start,
    // [100:85] key_length, [116:101] value_start, [132:117] value_length,
    // [148:133] line_number, [164:149] column, [167:165] zero
    output logic [167:0]      m_tdata,
    output logic              m_tlast     // run_end
);

    ilt_pkg::state_t state_reg;
    ilt_pkg::state_t state_next;
    ilt_pkg::state_t step_nxt;
    ilt_pkg::res_t   res0;
    ilt_pkg::res_t   res1;
    ilt_pkg::res_t   out_res;
    logic [1:0]      res_cnt;
    logic [1:0]      wr_cnt;
    logic            accept;

    assign accept = s_tvalid && s_tready;

    ilt_step u_step (
        .cur        (state_reg),
        .byte_value (s_tdata),
        .final_byte (s_tlast),
        .nxt        (step_nxt),
        .res0       (res0),
        .res1       (res1),
        .res_cnt    (res_cnt)
    );

    assign wr_cnt     = accept ? res_cnt : 2'd0;
    assign state_next = accept ? step_nxt : state_reg;

    ilt_res_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cnt   (wr_cnt),
        .wr0      (res0),
        .wr1      (res1),
        .room_two (s_tready),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (out_res)
    );

    assign m_tdata = {3'b000,
                      out_res.column,
                      out_res.line_number,
                      out_res.value_length,
                      out_res.value_start,
                      out_res.key_length,
                      out_res.key_start,
                      out_res.section_column,
                      out_res.section_line,
                      out_res.section_length,
                      out_res.section_start,
                      out_res.event_res};
    assign m_tlast = out_res.run_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ilt_pkg::STATE_RST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
